// ===== hdl/pnc_pkg.sv =====
// Package for the 3x3 positive neighbor counter: types, codes and field widths.
`timescale 1ns / 1ps
package pnc_pkg;

    localparam int DEFAULT_MAX_COLS = 32;
    localparam int DEFAULT_MAX_ROWS = 1024;

    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 4;
    localparam int CELL_ROW_W  = 10;
    localparam int CELL_COL_W  = 5;
    localparam int ROW_CFG_W   = 11;
    localparam int COL_CFG_W   = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int OUT_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        SEL_PREV  = 2'd0,
        SEL_END   = 2'd1,
        SEL_FLUSH = 2'd2
    } win_sel_t;

    typedef struct packed {
        logic     cfg_write;
        logic     accept;
        logic     load_out;
        win_sel_t sel;
        logic     last;
        logic     advance;
        logic     flush_inc;
    } pnc_cmd_t;

    typedef struct packed {
        logic has_prev;
        logic has_end;
        logic frame_end;
        logic flush_last;
        logic out_free;
    } pnc_status_t;

endpackage

// ===== hdl/positive_neighbor_count_3x3.sv =====
// Accept steps the state register; the first result then loads into the output register.
// A new cell is accepted only in the idle state, after all results of the previous cell
// are loaded; the last cell of a frame also loads one result per column of the frame.
// The result sequencer loads one result per cycle into the single output register when free.
// Reset (aresetn low, synchronous) sets both counts to 1 and clears all flags and positions.
`timescale 1ns / 1ps
module positive_neighbor_count_3x3 #(
    parameter int MAX_COLS = pnc_pkg::DEFAULT_MAX_COLS,
    parameter int MAX_ROWS = pnc_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pnc_pkg::VALUE_W-1:0]    s_tdata,    // cell_value[31:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pnc_pkg::OUT_DATA_W-1:0] m_tdata,    // neighbor_count[3:0], cell_row[13:4],
                                                       // cell_col[18:14], zero fill
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pnc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pnc_pkg::*;

    pnc_cmd_t    cmd;
    pnc_status_t status;

    pnc_control u_control (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pnc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_value (s_tdata),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== hdl/pnc_datapath.sv =====
// Datapath: configuration, row flag registers, window count and output register.
`timescale 1ns / 1ps
module pnc_datapath #(
    parameter int MAX_COLS = pnc_pkg::DEFAULT_MAX_COLS,
    parameter int MAX_ROWS = pnc_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pnc_pkg::pnc_cmd_t                   cmd,
    input  logic [pnc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pnc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [pnc_pkg::VALUE_W-1:0]         cell_value,
    output pnc_pkg::pnc_status_t                status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pnc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import pnc_pkg::*;

    localparam int CPW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LIM_W = 18;
    localparam int CLW   = 7;

    logic [ROW_CFG_W-1:0] row_count_reg;
    logic [COL_CFG_W-1:0] col_count_reg;
    logic [MAX_COLS-1:0]  upper_reg;
    logic [MAX_COLS-1:0]  middle_reg;
    logic [MAX_COLS-1:0]  current_reg;
    logic [PW-1:0]        row_pos_reg;
    logic [CPW-1:0]       col_pos_reg;
    logic [CPW-1:0]       flush_col_reg;
    logic                 m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    logic [LIM_W-1:0]     rows_lim;
    logic [CLW-1:0]       cols_lim;
    logic                 row_end;
    logic                 frame_end;
    logic                 positive;
    logic [MAX_COLS-1:0]  cur_new;
    logic [MAX_COLS-1:0]  win_a;
    logic [MAX_COLS-1:0]  win_m;
    logic [MAX_COLS-1:0]  win_b;
    logic [CPW-1:0]       win_col;
    logic [PW-1:0]        win_row;
    logic [COUNT_W-1:0]   win_count;

    function automatic logic [COUNT_W-1:0] count3(
        input logic [MAX_COLS-1:0] a,
        input logic [MAX_COLS-1:0] m,
        input logic [MAX_COLS-1:0] b,
        input logic [CPW-1:0]      j
    );
        logic [MAX_COLS+1:0] ea;
        logic [MAX_COLS+1:0] em;
        logic [MAX_COLS+1:0] eb;
        logic [2:0]          wa;
        logic [2:0]          wm;
        logic [2:0]          wb;
        ea = {1'b0, a, 1'b0};
        em = {1'b0, m, 1'b0};
        eb = {1'b0, b, 1'b0};
        wa = 3'(ea >> j);
        wm = 3'(em >> j);
        wb = 3'(eb >> j);
        return COUNT_W'(wa[0]) + COUNT_W'(wa[1]) + COUNT_W'(wa[2])
             + COUNT_W'(wm[0]) + COUNT_W'(wm[2])
             + COUNT_W'(wb[0]) + COUNT_W'(wb[1]) + COUNT_W'(wb[2]);
    endfunction

    always_comb begin
        if (row_count_reg == '0) begin
            rows_lim = LIM_W'(1);
        end else if (LIM_W'(row_count_reg) > LIM_W'(MAX_ROWS)) begin
            rows_lim = LIM_W'(MAX_ROWS);
        end else begin
            rows_lim = LIM_W'(row_count_reg);
        end
        if (col_count_reg == '0) begin
            cols_lim = CLW'(1);
        end else if (CLW'(col_count_reg) > CLW'(MAX_COLS)) begin
            cols_lim = CLW'(MAX_COLS);
        end else begin
            cols_lim = CLW'(col_count_reg);
        end
    end

    assign row_end   = (CLW'(col_pos_reg) + CLW'(1)) >= cols_lim;
    assign frame_end = row_end && ((LIM_W'(row_pos_reg) + LIM_W'(1)) >= rows_lim);
    assign positive  = (cell_value != '0) && !cell_value[VALUE_W-1];
    assign cur_new   = cmd.accept ? (current_reg | (MAX_COLS'(positive) << col_pos_reg))
                                  : current_reg;

    assign status.has_prev   = (row_pos_reg != '0) && (col_pos_reg != '0);
    assign status.has_end    = (row_pos_reg != '0) && row_end;
    assign status.frame_end  = frame_end;
    assign status.flush_last = (CLW'(flush_col_reg) + CLW'(1)) >= cols_lim;
    assign status.out_free   = !m_valid_reg || m_tready;

    always_comb begin
        case (cmd.sel)
            SEL_PREV: begin
                win_a   = upper_reg;
                win_m   = middle_reg;
                win_b   = current_reg;
                win_col = col_pos_reg - CPW'(1);
                win_row = row_pos_reg - PW'(1);
            end
            SEL_END: begin
                win_a   = upper_reg;
                win_m   = middle_reg;
                win_b   = current_reg;
                win_col = col_pos_reg;
                win_row = row_pos_reg - PW'(1);
            end
            default: begin
                win_a   = middle_reg;
                win_m   = current_reg;
                win_b   = '0;
                win_col = flush_col_reg;
                win_row = row_pos_reg;
            end
        endcase
        win_count = count3(win_a, win_m, win_b, win_col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_CFG_W'(1);
            col_count_reg <= COL_CFG_W'(1);
            upper_reg     <= '0;
            middle_reg    <= '0;
            current_reg   <= '0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            flush_col_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.cfg_write) begin
                if (cfg_index == REG_ROW_COUNT) begin
                    row_count_reg <= cfg_data;
                end else begin
                    col_count_reg <= cfg_data[COL_CFG_W-1:0];
                end
                upper_reg     <= '0;
                middle_reg    <= '0;
                current_reg   <= '0;
                row_pos_reg   <= '0;
                col_pos_reg   <= '0;
                flush_col_reg <= '0;
            end else if (cmd.advance) begin
                flush_col_reg <= '0;
                if (frame_end) begin
                    upper_reg   <= '0;
                    middle_reg  <= '0;
                    current_reg <= '0;
                    row_pos_reg <= '0;
                    col_pos_reg <= '0;
                end else if (row_end) begin
                    upper_reg   <= middle_reg;
                    middle_reg  <= cur_new;
                    current_reg <= '0;
                    col_pos_reg <= '0;
                    row_pos_reg <= row_pos_reg + PW'(1);
                end else begin
                    current_reg <= cur_new;
                    col_pos_reg <= col_pos_reg + CPW'(1);
                end
            end else begin
                current_reg <= cur_new;
                if (cmd.flush_inc) begin
                    flush_col_reg <= flush_col_reg + CPW'(1);
                end
            end

            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= {5'b0, CELL_COL_W'(win_col), CELL_ROW_W'(win_row), win_count};
            m_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/pnc_control.sv =====
// Controller: sequences the results of one transfer and steps the row state.
`timescale 1ns / 1ps
module pnc_control (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  pnc_pkg::pnc_status_t status,
    output pnc_pkg::pnc_cmd_t    cmd
);
    import pnc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREV,
        ST_END,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;

    always_comb begin
        state_next    = state_reg;
        cmd.cfg_write = cfg_valid && cfg_ready;
        cmd.accept    = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.sel       = SEL_PREV;
        cmd.last      = 1'b0;
        cmd.advance   = 1'b0;
        cmd.flush_inc = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    if (status.has_prev) begin
                        state_next = ST_PREV;
                    end else if (status.has_end) begin
                        state_next = ST_END;
                    end else if (status.frame_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_PREV: begin
                cmd.sel = SEL_PREV;
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.last     = !status.has_end && !status.frame_end;
                    if (status.has_end) begin
                        state_next = ST_END;
                    end else if (status.frame_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_END: begin
                cmd.sel = SEL_END;
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.last     = !status.frame_end;
                    if (status.frame_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                cmd.sel = SEL_FLUSH;
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.last     = status.flush_last;
                    if (status.flush_last) begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.flush_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for positive_neighbor_count_3x3: directed table, random frames.
`timescale 1ns / 1ps
module testbench;
    import pnc_pkg::*;

    localparam int MAX_COLS      = DEFAULT_MAX_COLS;
    localparam int MAX_ROWS      = DEFAULT_MAX_ROWS;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_CELLS  = 100;
    localparam int TALL_CELLS    = 16;
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [COUNT_W-1:0]    count;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_COL_W-1:0] col;
        logic                  last;
    } count_result_t;

    typedef enum logic [0:0] {
        STEP_CELL  = 1'b0,
        STEP_WRITE = 1'b1
    } step_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
        logic [VALUE_W-1:0]     value;
        logic                   typed;
        count_result_t          want;
    } step_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata;     // cell_value[31:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // neighbor_count[3:0], cell_row[13:4],
                                        // cell_col[18:14], zero fill
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    positive_neighbor_count_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // neighbor count predictor state
    logic [ROW_CFG_W-1:0] rows_reg;
    logic [COL_CFG_W-1:0] cols_reg;
    logic [MAX_COLS-1:0]  upper_flags;
    logic [MAX_COLS-1:0]  middle_flags;
    logic [MAX_COLS-1:0]  current_flags;
    int unsigned          row_pos;
    int unsigned          col_pos;

    count_result_t cell_results[$];
    count_result_t expected_counts[$];
    step_t         plan[$];

    int error_count;
    int cycle_count;
    int burst_left;
    int gap_left;
    bit hold_for_drain;
    bit drained_once;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned effective_size(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned positive_around(logic [MAX_COLS-1:0] above,
                                                    logic [MAX_COLS-1:0] centre,
                                                    logic [MAX_COLS-1:0] below,
                                                    int j);
        int unsigned n;
        n = 0;
        for (int k = j - 1; k <= j + 1; k++) begin
            if (k >= 0 && k < MAX_COLS) begin
                n += above[k] + below[k];
                if (k != j) n += centre[k];
            end
        end
        return n;
    endfunction

    function automatic void add_result(int unsigned cnt, int unsigned r, int unsigned c);
        count_result_t res;
        res.count = cnt[COUNT_W-1:0];
        res.row   = r[CELL_ROW_W-1:0];
        res.col   = c[CELL_COL_W-1:0];
        res.last  = 1'b0;
        cell_results.push_back(res);
    endfunction

    function automatic void clear_window();
        upper_flags   = '0;
        middle_flags  = '0;
        current_flags = '0;
        row_pos       = 0;
        col_pos       = 0;
    endfunction

    function automatic void load_size_register(logic [CFG_IDX_W-1:0] idx,
                                               logic [CFG_DATA_W-1:0] data);
        if (idx == REG_ROW_COUNT) rows_reg = data[ROW_CFG_W-1:0];
        else cols_reg = data[COL_CFG_W-1:0];
        clear_window();
    endfunction

    function automatic void predict_counts(logic [VALUE_W-1:0] value);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        bit          row_end;
        bit          frame_end;
        rows      = effective_size(rows_reg, MAX_ROWS);
        cols      = effective_size(cols_reg, MAX_COLS);
        r         = row_pos;
        c         = col_pos;
        row_end   = (c + 1 >= cols);
        frame_end = row_end && (r + 1 >= rows);
        cell_results.delete();
        if (value != '0 && !value[VALUE_W-1]) current_flags[c] = 1'b1;
        if (r >= 1 && c >= 1)
            add_result(positive_around(upper_flags, middle_flags, current_flags, c - 1),
                       r - 1, c - 1);
        if (r >= 1 && row_end)
            add_result(positive_around(upper_flags, middle_flags, current_flags, c), r - 1, c);
        if (frame_end) begin
            for (int j = 0; j < cols; j++)
                add_result(positive_around(middle_flags, current_flags, '0, j), r, j);
        end
        if (cell_results.size() > 0) cell_results[cell_results.size() - 1].last = 1'b1;
        if (frame_end) begin
            clear_window();
        end else if (row_end) begin
            upper_flags   = middle_flags;
            middle_flags  = current_flags;
            current_flags = '0;
            col_pos       = 0;
            row_pos       = r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic step_t cell_step(logic [VALUE_W-1:0] value);
        step_t s;
        s       = '0;
        s.kind  = STEP_CELL;
        s.value = value;
        return s;
    endfunction

    // single cell of a 1x1 matrix: one result, no neighbors, end of run
    function automatic step_t lone_cell(logic [VALUE_W-1:0] value);
        step_t s;
        s           = cell_step(value);
        s.typed     = 1'b1;
        s.want      = '0;
        s.want.last = 1'b1;
        return s;
    endfunction

    function automatic step_t write_step(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        step_t s;
        s       = '0;
        s.kind  = STEP_WRITE;
        s.index = idx;
        s.data  = data;
        return s;
    endfunction

    function automatic logic [VALUE_W-1:0] random_cell_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic wait_drained();
        while (expected_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic send_cell(logic [VALUE_W-1:0] value, logic typed, count_result_t want);
        if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_left) @(posedge aclk);
            if (hold_for_drain) wait_drained();
            gap_left       = 0;
            hold_for_drain = 1'b0;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_counts(value);
        if (typed) expected_counts.push_back(want);
        else foreach (cell_results[k]) expected_counts.push_back(cell_results[k]);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (!drained_once || $urandom_range(0, 9) == 0) begin
                hold_for_drain = 1'b1;
                drained_once   = 1'b1;
                if (gap_left == 0) gap_left = 1;
            end
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        load_size_register(idx, data);
    endtask

    task automatic run_frames(logic [CFG_DATA_W-1:0] row_word, logic [CFG_DATA_W-1:0] col_word,
                              int unsigned cells);
        if ($urandom_range(0, 1) == 1) begin
            write_register(REG_ROW_COUNT, row_word);
            write_register(REG_COL_COUNT, col_word);
        end else begin
            write_register(REG_COL_COUNT, col_word);
            write_register(REG_ROW_COUNT, row_word);
        end
        repeat (cells) send_cell(random_cell_value(), 1'b0, '0);
    endtask

    // result checker
    always @(posedge aclk) begin
        count_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata, 0);
            end else begin
                want = expected_counts.pop_front();
                if (m_tdata[3:0] != want.count)
                    report_mismatch("neighbor_count", m_tdata[3:0], want.count);
                if (m_tdata[13:4] != want.row)
                    report_mismatch("cell_row", m_tdata[13:4], want.row);
                if (m_tdata[18:14] != want.col)
                    report_mismatch("cell_col", m_tdata[18:14], want.col);
                if (m_tlast != want.last)
                    report_mismatch("last_of_run", m_tlast, want.last);
            end
        end
    end

    // receiver stall pattern and run limit
    always @(posedge aclk) begin
        cycle_count++;
        case ((cycle_count / 128) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= (cycle_count % 16) >= 10;
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned rows_data;
        int unsigned cols_data;
        int unsigned frame_cells;
        int unsigned cells;
        int unsigned random_cells;
        logic [CFG_DATA_W-1:0] col_word;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_ROW_COUNT;
        cfg_data       = '0;
        error_count    = 0;
        cycle_count    = 0;
        burst_left     = 4;
        gap_left       = 0;
        hold_for_drain = 1'b0;
        drained_once   = 1'b0;
        random_cells   = 0;
        rows_reg       = ROW_CFG_W'(1);
        cols_reg       = COL_CFG_W'(1);
        clear_window();

        plan = '{
            lone_cell(32'd1), lone_cell(32'h7FFF_FFFF), lone_cell(32'h8000_0000),
            lone_cell(32'd0),
            write_step(REG_ROW_COUNT, 11'd0), write_step(REG_COL_COUNT, 11'd0),
            lone_cell(32'hFFFF_FFFF),
            write_step(REG_ROW_COUNT, 11'd3), write_step(REG_COL_COUNT, 11'd3),
            cell_step(32'h7FFF_FFFF), cell_step(32'd1), cell_step(32'h4000_0000),
            cell_step(32'd5), cell_step(32'h8000_0000), cell_step(32'd7),
            cell_step(32'h1234_5678), cell_step(32'd1), cell_step(32'h7FFF_FFFF),
            write_step(REG_ROW_COUNT, 11'd2), write_step(REG_COL_COUNT, 11'h7C2),
            cell_step(32'd1), cell_step(32'd0), cell_step(32'd0), cell_step(32'd1),
            write_step(REG_ROW_COUNT, 11'd2047), write_step(REG_COL_COUNT, 11'd63),
            cell_step(32'd9), cell_step(32'hFFFF_FFFE), cell_step(32'd3)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_WRITE) write_register(plan[i].index, plan[i].data);
            else send_cell(plan[i].value, plan[i].typed, plan[i].want);
        end

        // tallest frame cut short, widest single row, widest double row
        run_frames(11'd1024, 11'd1, TALL_CELLS);
        run_frames(11'd1, 11'd63, MAX_COLS);
        run_frames(11'd2, 11'd32, 2 * MAX_COLS);

        while (random_cells < RANDOM_CELLS) begin
            rows_data = $urandom_range(0, 4);
            case ($urandom_range(0, 5))
                0:       cols_data = 0;
                1:       cols_data = $urandom_range(33, 63);
                2:       cols_data = MAX_COLS;
                default: cols_data = $urandom_range(1, 8);
            endcase
            col_word    = CFG_DATA_W'(cols_data | ($urandom_range(0, 31) << COL_CFG_W));
            frame_cells = effective_size(rows_data, MAX_ROWS) *
                          effective_size(cols_data, MAX_COLS);
            cells       = frame_cells * $urandom_range(1, 2);
            // cut a frame short now and then
            if ($urandom_range(0, 4) == 0) cells = $urandom_range(1, frame_cells);
            if (cells > RANDOM_CELLS - random_cells) cells = RANDOM_CELLS - random_cells;
            run_frames(CFG_DATA_W'(rows_data), col_word, cells);
            random_cells += cells;
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/pnc_pkg.sv
hdl/pnc_datapath.sv
hdl/pnc_control.sv
hdl/positive_neighbor_count_3x3.sv
test/testbench.sv
